[rtl/w2s_pkg.sv]
// Package: payload types, register indexes and constants for world_to_screen_projection.
package w2s_pkg;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } t_point;

    typedef struct packed {
        logic               visible;
        logic signed [19:0] screen_x;
        logic signed [19:0] screen_y;
    } t_screen;

    typedef enum logic [2:0] {
        REG_ROW_X_COEFS  = 3'd0,
        REG_ROW_X_OFFSET = 3'd1,
        REG_ROW_Y_COEFS  = 3'd2,
        REG_ROW_Y_OFFSET = 3'd3,
        REG_ROW_W_COEFS  = 3'd4,
        REG_ROW_W_OFFSET = 3'd5,
        REG_SCREEN_SIZE  = 3'd6
    } t_reg_idx;

    localparam int CFG_DW   = 48;
    localparam int CFG_AW   = 3;
    localparam int CLIP_W   = 52;   // |dot| < 3*2^46 + 2^43
    localparam int QW       = 52;   // quotient bits: cx*8W/cw, fractional bits for cw small
    localparam int NUM_W    = 67;   // |cx|*8W < 2^66
    localparam logic signed [CLIP_W-1:0] W_MIN = 52'sd268435;
    localparam logic signed [19:0] SCR_MAX = 20'sd524287;
    localparam logic signed [19:0] SCR_MIN = -20'sd524288;

    typedef struct packed {
        logic [47:0]        coefs;
        logic signed [31:0] offset;
    } t_row;

    // Control carried along the divider pipeline.
    typedef struct packed {
        logic               vis;
        logic signed [16:0] base_x;   // 8*W + 8, up to 32768
        logic signed [16:0] base_y;   // 8*H - 8
    } t_side;

endpackage

[rtl/world_to_screen_projection.sv]
// Top level: streaming world-to-screen perspective projection.
// One point transfer per cycle, one result transfer per point. The pipe is made of
// two multiply/sum stages, a scale stage, a divider load stage, one stage per quotient
// bit of the divider, a floor/sign stage and a final offset/saturate stage; the whole
// pipe advances together and holds when the output register is full and not taken.
// Configuration writes apply from the next edge.
module world_to_screen_projection (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  w2s_pkg::t_point                i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output w2s_pkg::t_screen               o_data,
    input  logic                           i_cfg_we,
    input  logic [w2s_pkg::CFG_AW-1:0]     i_cfg_idx,
    input  logic [w2s_pkg::CFG_DW-1:0]     i_cfg_data
);
    localparam int LAT = w2s_pkg::NUM_W + 6;

    w2s_pkg::t_row r_rx, r_ry, r_rw;
    logic [23:0]   r_size;
    logic          en;
    logic [LAT-1:0] r_v;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx <= '0; r_ry <= '0; r_rw <= '0; r_size <= '0;
        end else if (i_cfg_we) begin
            case (w2s_pkg::t_reg_idx'(i_cfg_idx))
                w2s_pkg::REG_ROW_X_COEFS:  r_rx.coefs  <= i_cfg_data;
                w2s_pkg::REG_ROW_X_OFFSET: r_rx.offset <= i_cfg_data[31:0];
                w2s_pkg::REG_ROW_Y_COEFS:  r_ry.coefs  <= i_cfg_data;
                w2s_pkg::REG_ROW_Y_OFFSET: r_ry.offset <= i_cfg_data[31:0];
                w2s_pkg::REG_ROW_W_COEFS:  r_rw.coefs  <= i_cfg_data;
                w2s_pkg::REG_ROW_W_OFFSET: r_rw.offset <= i_cfg_data[31:0];
                w2s_pkg::REG_SCREEN_SIZE:  r_size      <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Advance the pipe unless the last stage holds a result nobody takes.
    assign en      = !r_v[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_v <= '0;
        else if (en)
            r_v <= {r_v[LAT-2:0], i_valid};
    end

    // Stages 1-2: clip values.
    logic signed [w2s_pkg::CLIP_W-1:0] cx, cy, cw;
    w2s_dot u_dx (.i_clk, .i_en(en), .i_row(r_rx), .i_pt(i_data), .o_dot(cx));
    w2s_dot u_dy (.i_clk, .i_en(en), .i_row(r_ry), .i_pt(i_data), .o_dot(cy));
    w2s_dot u_dw (.i_clk, .i_en(en), .i_row(r_rw), .i_pt(i_data), .o_dot(cw));

    // Stage 3: scale magnitudes by 8*W and 8*H; settle visibility.
    logic [14:0] sw, shh;
    assign sw  = {r_size[11:0], 3'b0};
    assign shh = {r_size[23:12], 3'b0};

    logic [w2s_pkg::NUM_W-1:0]  r_nx, r_ny;
    logic                        r_sx, r_sy;
    logic [w2s_pkg::CLIP_W-2:0] r_den;
    w2s_pkg::t_side              r_side;
    logic [w2s_pkg::CLIP_W-1:0] ax, ay;
    logic                        vis;
    assign ax  = cx[w2s_pkg::CLIP_W-1] ? -cx : cx;
    assign ay  = cy[w2s_pkg::CLIP_W-1] ? -cy : cy;
    assign vis = cw > w2s_pkg::W_MIN;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx   <= w2s_pkg::NUM_W'(ax) * w2s_pkg::NUM_W'(sw);
            r_ny   <= w2s_pkg::NUM_W'(ay) * w2s_pkg::NUM_W'(shh);
            r_sx   <= cx[w2s_pkg::CLIP_W-1];
            r_sy   <= cy[w2s_pkg::CLIP_W-1];
            r_den  <= vis ? cw[w2s_pkg::CLIP_W-2:0] : (w2s_pkg::CLIP_W-1)'(1);
            r_side <= '{vis, 17'(sw) + 17'sd8, 17'(shh) - 17'sd8};
        end
    end

    // Dividers; side data travels alongside.
    logic signed [w2s_pkg::QW+1:0] qx, qy;
    w2s_div u_vx (.i_clk, .i_en(en), .i_neg(r_sx), .i_num(r_nx), .i_den(r_den), .o_q(qx));
    w2s_div u_vy (.i_clk, .i_en(en), .i_neg(r_sy), .i_num(r_ny), .i_den(r_den), .o_q(qy));

    w2s_pkg::t_side r_sd [0:w2s_pkg::NUM_W+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_side;
            for (int k = 1; k <= w2s_pkg::NUM_W + 1; k++)
                r_sd[k] <= r_sd[k-1];
        end
    end

    // Final stage: add base, saturate, zero when not visible.
    w2s_pkg::t_side fs;
    logic signed [w2s_pkg::QW+3:0] ex, ey;
    assign fs = r_sd[w2s_pkg::NUM_W+1];
    assign ex = (w2s_pkg::QW+4)'(fs.base_x) + (w2s_pkg::QW+4)'(qx);
    assign ey = (w2s_pkg::QW+4)'(fs.base_y) - (w2s_pkg::QW+4)'(qy);

    function automatic logic signed [19:0] sat(input logic signed [w2s_pkg::QW+3:0] v);
        if (v > (w2s_pkg::QW+4)'(w2s_pkg::SCR_MAX)) return w2s_pkg::SCR_MAX;
        if (v < (w2s_pkg::QW+4)'(w2s_pkg::SCR_MIN)) return w2s_pkg::SCR_MIN;
        return v[19:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en)
            o_data <= fs.vis ? '{1'b1, sat(ex), sat(ey)} : '0;
    end

    // Assertions.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipe stalled with empty output");
    a_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.visible |-> o_data.screen_x == 0 && o_data.screen_y == 0)
        else $error("hidden point has nonzero coordinates");
endmodule

[rtl/w2s_dot.sv]
// Module: one matrix row, three products then sum, two register stages.
module w2s_dot (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  w2s_pkg::t_row                        i_row,
    input  w2s_pkg::t_point                      i_pt,
    output logic signed [w2s_pkg::CLIP_W-1:0]    o_dot
);
    logic signed [47:0] r_px, r_py, r_pz;
    logic signed [43:0] r_off;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= $signed(i_row.coefs[15:0])  * i_pt.world_x;
            r_py  <= $signed(i_row.coefs[31:16]) * i_pt.world_y;
            r_pz  <= $signed(i_row.coefs[47:32]) * i_pt.world_z;
            r_off <= {i_row.offset, 12'd0};
            o_dot <= w2s_pkg::CLIP_W'(r_px) + w2s_pkg::CLIP_W'(r_py)
                   + w2s_pkg::CLIP_W'(r_pz) + w2s_pkg::CLIP_W'(r_off);
        end
    end
endmodule

[rtl/w2s_div.sv]
// Module: pipelined restoring divider, one quotient bit per stage, floor on sign.
module w2s_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic                              i_neg,
    input  logic [w2s_pkg::NUM_W-1:0]         i_num,   // magnitude
    input  logic [w2s_pkg::CLIP_W-2:0]        i_den,   // positive
    output logic signed [w2s_pkg::QW+1:0]     o_q      // floored signed quotient
);
    localparam int N  = w2s_pkg::NUM_W;
    localparam int DW = w2s_pkg::CLIP_W - 1;
    localparam int RW = DW + 1;

    logic [N-1:0]  r_n   [0:N];
    logic [RW-1:0] r_rem [0:N];
    logic [DW-1:0] r_d   [0:N];
    logic          r_ng  [0:N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= i_num;
            r_rem[0] <= '0;
            r_d[0]   <= i_den;
            r_ng[0]  <= i_neg;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [RW:0] sh;
        logic [RW:0] df;
        assign sh = {r_rem[s], r_n[s][N-1]};
        assign df = sh - {2'b0, r_d[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= df[RW] ? sh[RW-1:0] : df[RW-1:0];
                r_n[s+1]   <= {r_n[s][N-2:0], ~df[RW]};
                r_d[s+1]   <= r_d[s];
                r_ng[s+1]  <= r_ng[s];
            end
        end
    end

    logic [w2s_pkg::QW+1:0] q;
    assign q = (w2s_pkg::QW+2)'(r_n[N]);
    always_ff @(posedge i_clk) begin
        if (i_en)
            o_q <= r_ng[N] ? $signed(-q - {{(w2s_pkg::QW+1){1'b0}}, (r_rem[N] != '0)})
                           : $signed(q);
    end
endmodule
